@@ src/sequential_list_engine_unit_defines.svh @@
// Assertion macros shared by the checker of the list engine.
// Depends on nothing; the asserting file must have clk and rst in scope.
`ifndef SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_UNIT_DEFINES_SVH

// A property that must hold at every rising clock edge outside reset.
`define SLE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("list engine check failed");

// A condition in one cycle that implies another condition in the next cycle.
`define SLE_ASSERT_NEXT(label, cause, effect) \
  `SLE_ASSERT(label, (cause) |=> (effect))

`endif

@@ src/sle_pkg.sv @@
// Package for the list engine: sizes, command, status and state codes, cell control.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_REVERSE = 2'd2,
    ACT_DUMP    = 2'd3
  } sle_action_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_FULL    = 2'd2
  } sle_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_DUMP
  } sle_state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DOWN,
    CELL_ROT
  } sle_cell_mode_t;

  typedef struct packed {
    sle_cell_mode_t   mode;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } sle_cell_ctl_t;

endpackage

@@ src/sle_cell.sv @@
// One storage cell of the list chain: holds one element byte.
// Depends on sle_pkg for the cell control struct and widths.
`timescale 1ns / 1ps

module sle_cell (
  input  logic                       clk,
  input  logic [sle_pkg::IDX_W-1:0]  idx,
  input  sle_pkg::sle_cell_ctl_t     ctl,
  input  logic [7:0]                 left,
  input  logic [7:0]                 right,
  input  logic [7:0]                 bus,
  output logic [7:0]                 data
);

  always_ff @(posedge clk) begin
    case (ctl.mode)
      sle_pkg::CELL_UP: begin
        // The cell at the insertion point takes the new byte; those above it
        // move up by one.
        if (idx == ctl.lo) begin
          data <= bus;
        end else if (idx > ctl.lo && idx <= ctl.hi) begin
          data <= left;
        end
      end
      sle_pkg::CELL_DOWN: begin
        if (idx >= ctl.lo && idx < ctl.hi) begin
          data <= right;
        end
      end
      sle_pkg::CELL_ROT: begin
        // The top of the rotated span receives the old head from the bus.
        if (idx == ctl.hi) begin
          data <= bus;
        end else if (idx >= ctl.lo && idx < ctl.hi) begin
          data <= right;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ src/sequential_list_engine_unit.sv @@
// Top level of the list engine: command sequencer, output register, cell chain.
// Depends on sle_pkg and sle_cell.
//
// Usage: a command word enters on cmd_valid/cmd_stall with action, position
// and value; result words leave on res_valid/res_stall with status, item,
// item_valid, list_length and last. The list lives in a chain of CAPACITY
// cells, each holding one byte and passing it to a neighbour when told.
// Insert and delete shift the chain in the cycle the command is taken, so
// their single result appears in the next cycle.
// Reverse rotates a shrinking prefix of the list left once per cycle, down to
// a prefix of two, then gives one result; a shorter list is not rotated.
// Dump rotates the whole list once per result word, count words at one per
// cycle while the result side does not stall, and leaves the list as it was;
// an empty dump gives a single word. A new command is taken only when the
// sequencer is idle and the output register is free or being emptied. A stall
// on the result side freezes the held word and pauses a dump in place. Reset
// empties the list and clears res_valid; cells and result fields are not reset.
`timescale 1ns / 1ps

module sequential_list_engine_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] action,
  input  logic [6:0] position,
  input  logic [7:0] value,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] status,
  output logic [7:0] item,
  output logic       item_valid,
  output logic [6:0] list_length,
  output logic       last
);

  sle_pkg::sle_state_t         state, state_next;
  logic [sle_pkg::CNT_W-1:0]   count, count_next;
  logic [sle_pkg::CNT_W-1:0]   rot_len, rot_len_next;
  logic [sle_pkg::CNT_W-1:0]   dump_left, dump_left_next;
  logic                        res_valid_next;
  logic [1:0]                  status_next;
  logic [7:0]                  item_next;
  logic                        item_valid_next;
  logic                        last_next;
  logic                        load;
  logic                        out_free;
  logic                        accept;
  logic [7:0]                  pos_w, cnt_w;
  logic [7:0]                  bus;
  logic [7:0]                  head;
  sle_pkg::sle_cell_ctl_t      ctl;
  logic [7:0]                  cell_data [sle_pkg::CAPACITY];

  assign out_free  = !res_valid || !res_stall;
  assign cmd_stall = !(state == sle_pkg::S_IDLE && out_free);
  assign accept    = cmd_valid && !cmd_stall;
  assign pos_w     = 8'(position);
  assign cnt_w     = 8'(count);
  assign head      = cell_data[0];

  always_comb begin
    state_next      = state;
    count_next      = count;
    rot_len_next    = rot_len;
    dump_left_next  = dump_left;
    ctl.mode        = sle_pkg::CELL_HOLD;
    ctl.lo          = '0;
    ctl.hi          = '0;
    bus             = value;
    load            = 1'b0;
    status_next     = sle_pkg::STATUS_OK;
    item_next       = 8'd0;
    item_valid_next = 1'b0;
    last_next       = 1'b1;
    case (state)
      sle_pkg::S_IDLE: begin
        if (accept) begin
          case (sle_pkg::sle_action_t'(action))
            sle_pkg::ACT_INSERT: begin
              load = 1'b1;
              if (pos_w == 8'd0 || pos_w > cnt_w + 8'd1) begin
                status_next = sle_pkg::STATUS_BAD_POS;
              end else if (count == sle_pkg::CNT_W'(sle_pkg::CAPACITY)) begin
                status_next = sle_pkg::STATUS_FULL;
              end else begin
                ctl.mode   = sle_pkg::CELL_UP;
                ctl.lo     = sle_pkg::IDX_W'(position - 7'd1);
                ctl.hi     = sle_pkg::IDX_W'(count);
                count_next = count + 1'b1;
              end
            end
            sle_pkg::ACT_DELETE: begin
              load = 1'b1;
              if (pos_w == 8'd0 || pos_w > cnt_w) begin
                status_next = sle_pkg::STATUS_BAD_POS;
              end else begin
                ctl.mode   = sle_pkg::CELL_DOWN;
                ctl.lo     = sle_pkg::IDX_W'(position - 7'd1);
                ctl.hi     = sle_pkg::IDX_W'(count - 1'b1);
                count_next = count - 1'b1;
              end
            end
            sle_pkg::ACT_REVERSE: begin
              if (count >= sle_pkg::CNT_W'(2)) begin
                state_next   = sle_pkg::S_ROT;
                rot_len_next = count;
              end else begin
                load = 1'b1;
              end
            end
            default: begin
              if (count == '0) begin
                load = 1'b1;
              end else begin
                state_next     = sle_pkg::S_DUMP;
                dump_left_next = count;
              end
            end
          endcase
        end
      end
      sle_pkg::S_ROT: begin
        // Rotating prefixes of length count, count-1, ..., 2 left by one
        // place each reverses the list.
        if (rot_len >= sle_pkg::CNT_W'(2)) begin
          ctl.mode     = sle_pkg::CELL_ROT;
          ctl.hi       = sle_pkg::IDX_W'(rot_len - 1'b1);
          bus          = head;
          rot_len_next = rot_len - 1'b1;
        end else if (out_free) begin
          load       = 1'b1;
          state_next = sle_pkg::S_IDLE;
        end
      end
      sle_pkg::S_DUMP: begin
        if (out_free) begin
          load            = 1'b1;
          item_next       = head;
          item_valid_next = 1'b1;
          last_next       = (dump_left == sle_pkg::CNT_W'(1));
          ctl.mode        = sle_pkg::CELL_ROT;
          ctl.hi          = sle_pkg::IDX_W'(count - 1'b1);
          bus             = head;
          dump_left_next  = dump_left - 1'b1;
          if (dump_left == sle_pkg::CNT_W'(1)) begin
            state_next = sle_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = sle_pkg::S_IDLE;
      end
    endcase
    res_valid_next = load || (res_valid && res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sle_pkg::S_IDLE;
      count     <= '0;
      rot_len   <= '0;
      dump_left <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rot_len   <= rot_len_next;
      dump_left <= dump_left_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= status_next;
      item        <= item_next;
      item_valid  <= item_valid_next;
      list_length <= 7'(count_next);
      last        <= last_next;
    end
  end

  for (genvar gi = 0; gi < sle_pkg::CAPACITY; gi++) begin : g_cell
    logic [7:0] left_in, right_in;
    if (gi == 0) begin : g_first
      assign left_in = 8'd0;
    end else begin : g_mid_l
      assign left_in = cell_data[gi-1];
    end
    if (gi == sle_pkg::CAPACITY - 1) begin : g_end
      assign right_in = 8'd0;
    end else begin : g_mid_r
      assign right_in = cell_data[gi+1];
    end
    sle_cell u_cell (
      .clk   (clk),
      .idx   (sle_pkg::IDX_W'(gi)),
      .ctl   (ctl),
      .left  (left_in),
      .right (right_in),
      .bus   (bus),
      .data  (cell_data[gi])
    );
  end

endmodule

@@ src/sle_checker.sv @@
// Port-level checker for the list engine, attached to the top level by bind.
// Depends on sle_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "sequential_list_engine_unit_defines.svh"

module sle_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_stall,
  input logic [1:0] status,
  input logic [7:0] item,
  input logic       item_valid,
  input logic [6:0] list_length,
  input logic       last
);

  // A stalled result word stays offered, with item and last unchanged.
  `SLE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(item) && $stable(last))
  // Element words from a dump always report success.
  `SLE_ASSERT(a_item_ok, !(res_valid && item_valid) || status == sle_pkg::STATUS_OK)
  // Words without an element carry a zero byte and close their command.
  `SLE_ASSERT(a_no_item, !(res_valid && !item_valid) || (item == 8'd0 && last))
  // The reported length never exceeds the store.
  `SLE_ASSERT(a_len_cap, !res_valid || list_length <= 7'(sle_pkg::CAPACITY))

endmodule

bind sequential_list_engine_unit sle_checker u_sle_checker (.*);

@@ tb/tb.sv @@
// Self-checking testbench for sequential_list_engine_unit: random and directed list commands.
// A driver and a monitor run on the clock, and a shadow list predicts every result word.
// Depends on sle_pkg and the RTL of the list engine.
`timescale 1ns / 1ps

module tb;
  import sle_pkg::*;

  typedef struct packed {
    sle_action_t act;
    logic [6:0]  pos;
    logic [7:0]  val;
  } list_cmd_t;

  typedef struct packed {
    sle_status_t status;
    logic [7:0]  item;
    logic        item_valid;
    logic [6:0]  list_length;
    logic        last;
  } list_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic       cmd_stall;
  logic [1:0] action = 2'd0;
  logic [6:0] position = 7'd0;
  logic [7:0] value = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [1:0] status;
  logic [7:0] item;
  logic       item_valid;
  logic [6:0] list_length;
  logic       last;

  sequential_list_engine_unit uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .action(action), .position(position), .value(value),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .item(item), .item_valid(item_valid),
    .list_length(list_length), .last(last)
  );

  list_cmd_t  pending_cmds[$];
  list_word_t expected_words[$];

  // Shadow copy of the list held by the block.
  logic [7:0] shadow_list[CAPACITY];
  int         shadow_len = 0;

  int gen_len = 0;
  int total_cmds = 0;
  int cmds_accepted = 0;
  int words_checked = 0;
  int fault_count = 0;
  int peak_len = 0;
  int n_full = 0;
  int n_bad_pos = 0;
  int n_by_action[4] = '{0, 0, 0, 0};

  int  send_gap = 0;
  int  recv_hold = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;
  list_cmd_t  next_cmd;
  list_word_t exp_w;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL sequential_list_engine_unit");
    $finish;
  end

  // Works out the result words of one accepted command and updates the shadow list.
  function automatic void apply_list_command(sle_action_t act, logic [6:0] pos,
                                             logic [7:0] val);
    list_word_t w;
    int p;
    int k;
    logic [7:0] t;
    p = int'(pos);
    w = '{status: STATUS_OK, item: 8'd0, item_valid: 1'b0, list_length: 7'd0, last: 1'b1};
    n_by_action[act]++;
    case (act)
      ACT_INSERT: begin
        if (p < 1 || p > shadow_len + 1) begin
          w.status = STATUS_BAD_POS;
          n_bad_pos++;
        end else if (shadow_len >= CAPACITY) begin
          w.status = STATUS_FULL;
          n_full++;
        end else begin
          for (k = shadow_len; k > p - 1; k--) shadow_list[k] = shadow_list[k - 1];
          shadow_list[p - 1] = val;
          shadow_len++;
        end
      end
      ACT_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          w.status = STATUS_BAD_POS;
          n_bad_pos++;
        end else begin
          for (k = p - 1; k + 1 < shadow_len; k++) shadow_list[k] = shadow_list[k + 1];
          shadow_len--;
        end
      end
      ACT_REVERSE: begin
        for (k = 0; k < shadow_len / 2; k++) begin
          t = shadow_list[k];
          shadow_list[k] = shadow_list[shadow_len - 1 - k];
          shadow_list[shadow_len - 1 - k] = t;
        end
      end
      default: begin
        // A dump of an empty list still gives one word, with no element on it.
        if (shadow_len > 0) begin
          for (k = 0; k < shadow_len; k++) begin
            w.item = shadow_list[k];
            w.item_valid = 1'b1;
            w.list_length = 7'(shadow_len);
            w.last = (k == shadow_len - 1);
            expected_words.push_back(w);
          end
          return;
        end
      end
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
    w.list_length = 7'(shadow_len);
    expected_words.push_back(w);
  endfunction

  // Queues a command and follows the list length it leads to, so that positions can be chosen.
  function automatic void queue_command(sle_action_t act, int pos, logic [7:0] val);
    if (act == ACT_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
      gen_len++;
    else if (act == ACT_DELETE && pos >= 1 && pos <= gen_len)
      gen_len--;
    pending_cmds.push_back('{act: act, pos: 7'(pos), val: val});
  endfunction

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'h00;
    if (r < 10) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Draws one command with the given weights in percent; most positions are in range.
  function automatic void random_command(int ins_w, int del_w, int rev_w);
    int r;
    int pos;
    sle_action_t act;
    r = $urandom_range(0, 99);
    if (r < ins_w) act = ACT_INSERT;
    else if (r < ins_w + del_w) act = ACT_DELETE;
    else if (r < ins_w + del_w + rev_w) act = ACT_REVERSE;
    else act = ACT_DUMP;
    pos = $urandom_range(0, CAPACITY);
    if (act == ACT_INSERT) begin
      if ($urandom_range(0, 99) < 12) begin
        if (gen_len + 2 <= CAPACITY && $urandom_range(0, 1) == 1)
          pos = $urandom_range(gen_len + 2, CAPACITY);
        else
          pos = 0;
      end else begin
        pos = $urandom_range(1, (gen_len + 1 > CAPACITY) ? CAPACITY : gen_len + 1);
      end
    end else if (act == ACT_DELETE) begin
      if (gen_len > 0 && $urandom_range(0, 99) >= 12)
        pos = $urandom_range(1, gen_len);
      else if (gen_len + 1 <= CAPACITY && $urandom_range(0, 1) == 1)
        pos = $urandom_range(gen_len + 1, CAPACITY);
      else
        pos = 0;
    end
    queue_command(act, pos, pick_value());
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    int seg_mode;
    int seg_len;
    int n;

    // Empty list, bad positions on both sides, single element, odd and even reversal.
    queue_command(ACT_DUMP, 0, 8'h00);
    queue_command(ACT_REVERSE, 64, 8'hFF);
    queue_command(ACT_DELETE, 1, 8'h00);
    queue_command(ACT_DELETE, 0, 8'h00);
    queue_command(ACT_INSERT, 0, 8'hAA);
    queue_command(ACT_INSERT, 2, 8'hAA);
    queue_command(ACT_INSERT, 64, 8'h55);
    queue_command(ACT_INSERT, 1, 8'h00);
    queue_command(ACT_REVERSE, 0, 8'h00);
    queue_command(ACT_DUMP, 64, 8'hFF);
    queue_command(ACT_INSERT, 2, 8'hFF);
    queue_command(ACT_INSERT, 1, 8'h55);
    queue_command(ACT_INSERT, 2, 8'h7F);
    queue_command(ACT_INSERT, 5, 8'h80);
    queue_command(ACT_INSERT, 7, 8'h01);
    queue_command(ACT_DUMP, 0, 8'h00);
    queue_command(ACT_REVERSE, 0, 8'h00);
    queue_command(ACT_DUMP, 0, 8'h00);
    queue_command(ACT_DELETE, 6, 8'h00);
    queue_command(ACT_DELETE, 5, 8'h00);
    queue_command(ACT_DELETE, 1, 8'h00);
    queue_command(ACT_DELETE, 2, 8'h00);
    queue_command(ACT_REVERSE, 0, 8'h00);
    queue_command(ACT_DUMP, 0, 8'h00);
    queue_command(ACT_DELETE, 64, 8'h00);

    // Fill to capacity first so that refusals, full dumps and full reversal are reached.
    while (gen_len < CAPACITY) random_command(90, 3, 3);
    queue_command(ACT_INSERT, $urandom_range(1, CAPACITY), pick_value());
    queue_command(ACT_INSERT, 0, pick_value());
    queue_command(ACT_DUMP, 0, 8'h00);
    queue_command(ACT_REVERSE, 0, 8'h00);
    queue_command(ACT_DUMP, 0, 8'h00);

    while (pending_cmds.size() < 470) begin
      seg_mode = $urandom_range(0, 4);
      seg_len = $urandom_range(20, 60);
      case (seg_mode)
        0: for (n = 0; n < seg_len; n++) random_command(70, 10, 10);
        1: for (n = 0; n < seg_len; n++) random_command(10, 70, 10);
        2: for (n = 0; n < seg_len; n++) random_command(35, 30, 15);
        3: begin
          while (gen_len < CAPACITY) random_command(90, 4, 3);
          random_command(100, 0, 0);
          random_command(0, 0, 0);
        end
        default: begin
          while (gen_len > 0) random_command(4, 90, 3);
          random_command(0, 100, 0);
          random_command(0, 0, 0);
        end
      endcase
    end
    total_cmds = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (cmds_accepted == total_cmds);
    wait (expected_words.size() == 0);
    repeat (80) @(posedge clk);

    $display("Ran %0d commands: %0d inserts, %0d deletes, %0d reverses, %0d dumps.",
             cmds_accepted, n_by_action[ACT_INSERT], n_by_action[ACT_DELETE],
             n_by_action[ACT_REVERSE], n_by_action[ACT_DUMP]);
    $display("Checked %0d result words; peak length %0d, %0d full refusals, %0d bad positions.",
             words_checked, peak_len, n_full, n_bad_pos);
    if (fault_count == 0 && expected_words.size() == 0) begin
      $display("PASS sequential_list_engine_unit");
    end else begin
      $display("FAIL sequential_list_engine_unit");
    end
    $finish;
  end

  // Command driver: presents the queued commands with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        apply_list_command(sle_action_t'(action), position, value);
        cmds_accepted++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (send_gap > 0) begin
          cmd_valid <= 1'b0;
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          action <= next_cmd.act;
          position <= next_cmd.pos;
          value <= next_cmd.val;
          cmd_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : $urandom_range(0, 10);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stalls at random and checks each word against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: unexpected result word status=%0d item=%02h valid=%0b len=%0d last=%0b",
                     $time, status, item, item_valid, list_length, last);
        end else begin
          exp_w = expected_words.pop_front();
          if ({status, item, item_valid, list_length, last} !== exp_w) begin
            fault_count++;
            if (fault_count <= 10)
              $display("%0t: mismatch expected status=%0d item=%02h valid=%0b len=%0d last=%0b, %s",
                       $time, exp_w.status, exp_w.item, exp_w.item_valid, exp_w.list_length,
                       exp_w.last,
                       $sformatf("got status=%0d item=%02h valid=%0b len=%0d last=%0b",
                                 status, item, item_valid, list_length, last));
          end
        end
        if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
        recv_hold = recv_calm ? 0 : $urandom_range(0, 10);
      end
      if (recv_hold > 0) begin
        res_stall <= 1'b1;
        recv_hold--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

endmodule

@@ sequential_list_engine_unit.f @@
+incdir+src
src/sle_pkg.sv
src/sle_cell.sv
src/sequential_list_engine_unit.sv
src/sle_checker.sv
tb/tb.sv
